@@ rtl/rmv_pkg.sv @@
// Shared types and constants for the running mean and variance block.
// Used by the controller, the datapath, the divider and the top level.
// No dependencies.
package rmv_pkg;

  localparam int unsigned SAMPLE_W   = 32;  // sample and mean width
  localparam int unsigned SUM_W      = 64;  // squared-deviation sum and variance width
  localparam int unsigned SEEN_W     = 32;  // reported count width
  localparam int unsigned DIVIDEND_W = 64;
  localparam int unsigned ITER_W     = 7;   // holds ITER_LONG
  localparam logic [ITER_W-1:0] ITER_LONG  = 7'd64;
  localparam logic [ITER_W-1:0] ITER_SHORT = 7'd32;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV1 = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_ACC  = 7'b0001000,
    S_DIV2 = 7'b0010000,
    S_OUT  = 7'b0100000,
    S_MEAN = 7'b1000000
  } rmv_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic first_upd;   // start a new set with the accepted sample
    logic begin_step;  // capture the sample, start the mean division
    logic mean_upd;    // commit the new mean, form the second difference
    logic mul;         // multiply the two difference magnitudes
    logic acc;         // accumulate, commit the count, start the variance division
    logic var_latch;   // store the variance quotient
    logic out_load;    // load the result register
  } rmv_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic first;       // accepted sample opens a new set
    logic div_busy;
    logic div_done;
  } rmv_status_t;

endpackage

@@ rtl/rmv_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// 32 or 64 iterations selected at start. Uses rmv_pkg.
module rmv_div #(
  parameter int unsigned DIV_W = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             short_op,
  input  logic [rmv_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [DIV_W-1:0]                 divisor,
  output logic                             busy,
  output logic                             done,
  output logic [rmv_pkg::DIVIDEND_W-1:0]   quotient
);

  logic                           busy_r;
  logic                           done_r;
  logic [rmv_pkg::ITER_W-1:0]     iter_r;
  logic [DIV_W-1:0]               rem_r;
  logic [DIV_W-1:0]               rem_nxt;
  logic [rmv_pkg::DIVIDEND_W-1:0] quo_r;
  logic [rmv_pkg::DIVIDEND_W-1:0] quo_nxt;
  logic [DIV_W-1:0]               divisor_r;
  logic [DIV_W:0]                 partial;
  logic [DIV_W:0]                 diff;
  logic                           ge;

  // The remainder always stays below the divisor, so the shifted partial
  // remainder fits in one extra bit.
  always_comb begin
    partial = {rem_r, quo_r[rmv_pkg::DIVIDEND_W-1]};
    diff    = partial - {1'b0, divisor_r};
    ge      = ~diff[DIV_W];
    rem_nxt = ge ? diff[DIV_W-1:0] : partial[DIV_W-1:0];
    quo_nxt = {quo_r[rmv_pkg::DIVIDEND_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        iter_r <= short_op ? rmv_pkg::ITER_SHORT : rmv_pkg::ITER_LONG;
      end else if (busy_r) begin
        iter_r <= iter_r - 1'b1;
        if (iter_r == rmv_pkg::ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r     <= '0;
      quo_r     <= dividend;
      divisor_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ rtl/rmv_dp.sv @@
// Datapath: statistics state, difference and mean logic, multiplier,
// saturating accumulator and result register. Uses rmv_pkg and rmv_div.
module rmv_dp #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rmv_pkg::rmv_cmd_t                   cmd,
  output rmv_pkg::rmv_status_t                status,
  input  logic signed [rmv_pkg::SAMPLE_W-1:0] sample,
  input  logic                                starts_new_set,
  output logic signed [rmv_pkg::SAMPLE_W-1:0] running_mean,
  output logic [rmv_pkg::SUM_W-1:0]           sample_variance,
  output logic [rmv_pkg::SEEN_W-1:0]          samples_seen,
  output logic                                variance_valid
);

  localparam int unsigned SW    = rmv_pkg::SAMPLE_W;
  localparam int unsigned EXT_W = (COUNT_BITS > rmv_pkg::SEEN_W) ? COUNT_BITS
                                                                 : rmv_pkg::SEEN_W;

  // Statistics state.
  logic [COUNT_BITS-1:0]          cnt_r;
  logic signed [SW-1:0]           mean_r;
  logic [rmv_pkg::SUM_W-1:0]      sum_r;
  logic [rmv_pkg::SUM_W-1:0]      var_r;
  logic                           var_valid_r;

  // Per-item working registers.
  logic signed [SW-1:0]           x_r;
  logic                           neg_r;
  logic [SW-1:0]                  mag1_r;
  logic [SW-1:0]                  mag2_r;
  logic [COUNT_BITS-1:0]          n_r;
  logic [rmv_pkg::SUM_W-1:0]      prod_r;

  // Result register.
  logic signed [SW-1:0]           mean_o_r;
  logic [rmv_pkg::SUM_W-1:0]      var_o_r;
  logic [rmv_pkg::SEEN_W-1:0]     seen_o_r;
  logic                           valid_o_r;

  logic [COUNT_BITS-1:0]          n_nxt;
  logic signed [SW:0]             d1;
  logic [SW-1:0]                  mag1;
  logic [SW-1:0]                  q;
  logic signed [SW:0]             step;
  logic signed [SW:0]             mean_new;
  logic signed [SW:0]             d2;
  logic [SW-1:0]                  mag2;
  logic [rmv_pkg::SUM_W:0]        sum_wide;
  logic [rmv_pkg::SUM_W-1:0]      sum_nxt;
  logic [EXT_W-1:0]               cnt_ext;
  logic [rmv_pkg::SEEN_W-1:0]     seen;

  logic                           div_start;
  logic [rmv_pkg::DIVIDEND_W-1:0] div_dividend;
  logic [COUNT_BITS-1:0]          div_divisor;
  logic                           div_busy;
  logic                           div_done;
  logic [rmv_pkg::DIVIDEND_W-1:0] div_quo;

  always_comb begin
    n_nxt = (cnt_r == {COUNT_BITS{1'b1}}) ? cnt_r : cnt_r + COUNT_BITS'(1);
    d1    = {sample[SW-1], sample} - {mean_r[SW-1], mean_r};
    mag1  = d1[SW] ? SW'(-d1) : d1[SW-1:0];

    // Both differences share a sign, so only magnitudes are multiplied.
    q        = div_quo[SW-1:0];
    step     = neg_r ? -$signed({1'b0, q}) : $signed({1'b0, q});
    mean_new = {mean_r[SW-1], mean_r} + step;
    d2       = {x_r[SW-1], x_r} - mean_new;
    mag2     = d2[SW] ? SW'(-d2) : d2[SW-1:0];

    sum_wide = {1'b0, sum_r} + {1'b0, prod_r};
    sum_nxt  = sum_wide[rmv_pkg::SUM_W] ? '1 : sum_wide[rmv_pkg::SUM_W-1:0];

    cnt_ext = EXT_W'(cnt_r);
    seen    = (cnt_ext > EXT_W'({rmv_pkg::SEEN_W{1'b1}})) ? '1
                                                          : cnt_ext[rmv_pkg::SEEN_W-1:0];
  end

  // The mean quotient fits in 32 bits, so its dividend sits in the upper
  // half and only 32 iterations are run.
  assign div_start    = cmd.begin_step | cmd.acc;
  assign div_dividend = cmd.begin_step ? {mag1, {SW{1'b0}}} : sum_nxt;
  assign div_divisor  = cmd.begin_step ? n_nxt : n_r - COUNT_BITS'(1);

  rmv_div #(
    .DIV_W(COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .short_op (cmd.begin_step),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      mean_r      <= '0;
      sum_r       <= '0;
      var_r       <= '0;
      var_valid_r <= 1'b0;
    end else begin
      if (cmd.first_upd) begin
        cnt_r       <= COUNT_BITS'(1);
        mean_r      <= sample;
        sum_r       <= '0;
        var_r       <= '0;
        var_valid_r <= 1'b0;
      end
      if (cmd.mean_upd) begin
        mean_r <= mean_new[SW-1:0];
      end
      if (cmd.acc) begin
        sum_r <= sum_nxt;
        cnt_r <= n_r;
      end
      if (cmd.var_latch) begin
        var_r       <= div_quo;
        var_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.begin_step) begin
      x_r    <= sample;
      neg_r  <= d1[SW];
      mag1_r <= mag1;
      n_r    <= n_nxt;
    end
    if (cmd.mean_upd) begin
      mag2_r <= mag2;
    end
    if (cmd.mul) begin
      prod_r <= rmv_pkg::SUM_W'(mag1_r * mag2_r);
    end
    if (cmd.out_load) begin
      mean_o_r  <= mean_r;
      var_o_r   <= var_r;
      seen_o_r  <= seen;
      valid_o_r <= var_valid_r;
    end
  end

  assign status.first    = starts_new_set | (cnt_r == '0);
  assign status.div_busy = div_busy;
  assign status.div_done = div_done;

  assign running_mean    = mean_o_r;
  assign sample_variance = var_o_r;
  assign samples_seen    = seen_o_r;
  assign variance_valid  = valid_o_r;

  a_valid_needs_two : assert property (@(posedge clk) disable iff (!rst_n)
    var_valid_r |-> (cnt_r >= COUNT_BITS'(2)))
    else $error("variance flagged valid with fewer than two samples");

  a_invalid_zero : assert property (@(posedge clk) disable iff (!rst_n)
    !var_valid_r |-> (var_r == '0))
    else $error("variance nonzero while not valid");

endmodule

@@ rtl/rmv_ctrl.sv @@
// Controller state machine: sequences one transaction through the
// datapath and owns the handshakes. Uses rmv_pkg.
module rmv_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  rmv_pkg::rmv_status_t status,
  output rmv_pkg::rmv_cmd_t    cmd
);

  rmv_pkg::rmv_state_t state_r;
  rmv_pkg::rmv_state_t state_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                accept;
  logic                out_free;

  assign in_ready = (state_r == rmv_pkg::S_IDLE);
  assign accept   = in_valid & in_ready;
  assign out_free = ~out_valid_r | out_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r & ~out_ready;
    case (state_r)
      rmv_pkg::S_IDLE: begin
        if (accept) begin
          if (status.first) begin
            cmd.first_upd = 1'b1;
            state_nxt     = rmv_pkg::S_OUT;
          end else begin
            cmd.begin_step = 1'b1;
            state_nxt      = rmv_pkg::S_DIV1;
          end
        end
      end
      rmv_pkg::S_DIV1: begin
        if (status.div_done) begin
          state_nxt = rmv_pkg::S_MEAN;
        end
      end
      rmv_pkg::S_MEAN: begin
        cmd.mean_upd = 1'b1;
        state_nxt    = rmv_pkg::S_MUL;
      end
      rmv_pkg::S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = rmv_pkg::S_ACC;
      end
      rmv_pkg::S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = rmv_pkg::S_DIV2;
      end
      rmv_pkg::S_DIV2: begin
        if (status.div_done) begin
          cmd.var_latch = 1'b1;
          state_nxt     = rmv_pkg::S_OUT;
        end
      end
      rmv_pkg::S_OUT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = rmv_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rmv_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmv_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_idle_div_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rmv_pkg::S_IDLE) |-> !status.div_busy)
    else $error("divider busy while controller idle");

  a_done_expected : assert property (@(posedge clk) disable iff (!rst_n)
    status.div_done |-> (state_r == rmv_pkg::S_DIV1 || state_r == rmv_pkg::S_DIV2))
    else $error("divider finished outside a division state");

  a_load_sets_valid : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result loaded without raising out valid");

endmodule

@@ rtl/running_mean_variance.sv @@
// Top level of the running mean and variance block.
// Uses rmv_pkg, rmv_ctrl and rmv_dp (which holds rmv_div).
//
// Welford online statistics on signed Q16.16 samples. Each input transaction
// carries one sample and a flag that starts a new set; each produces exactly
// one output transaction with the updated mean (Q16.16, division truncated
// toward zero), the sample variance (unsigned Q32.32, sum of squared
// deviations over count minus one, saturating), the count (clamped to 32
// bits) and a valid flag that is set once two samples are in the set. The
// block handles one sample at a time. The result of the first sample of a
// set passes through the output state into the output register once that
// register is free, and the next sample is taken after that load. Every
// other sample is taken only after the previous result is loaded: both
// divisions, by the new count and by the count minus one, go through one
// shared restoring divider that produces one quotient bit per cycle, 32
// iterations for the mean step and 64 for the variance, followed by the mean
// update, the 32 by 32 multiply, the saturating accumulate, the quotient
// capture and the result load. A finished result sits in an output
// register, so the next sample is accepted while that result still waits to
// be taken; a result that is ready while the previous one is still untaken
// waits until the output register frees up. COUNT_BITS sets the width of
// the saturating sample counter and of the divider's divisor.
module running_mean_variance #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [31:0] sample
  input  logic [0:0]   in_tuser,   // [0] starts_new_set
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // [31:0] running_mean, [95:32] sample_variance,
                                   // [127:96] samples_seen
  output logic [0:0]   out_tuser   // [0] variance_valid
);

  rmv_pkg::rmv_cmd_t                   cmd;
  rmv_pkg::rmv_status_t                status;
  logic signed [rmv_pkg::SAMPLE_W-1:0] running_mean;
  logic [rmv_pkg::SUM_W-1:0]           sample_variance;
  logic [rmv_pkg::SEEN_W-1:0]          samples_seen;
  logic                                variance_valid;

  rmv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .status    (status),
    .cmd       (cmd)
  );

  rmv_dp #(
    .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .sample          ($signed(in_tdata)),
    .starts_new_set  (in_tuser[0]),
    .running_mean    (running_mean),
    .sample_variance (sample_variance),
    .samples_seen    (samples_seen),
    .variance_valid  (variance_valid)
  );

  // Result fields packed from the lowest bit up.
  assign out_tdata = {samples_seen, sample_variance, running_mean};
  assign out_tuser = variance_valid;

endmodule

@@ tb/running_mean_variance_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for running_mean_variance: streams Q16.16 samples,
// predicts the running mean, sample variance and count, checks every result.
// Depends on rmv_pkg and the running_mean_variance RTL.
module running_mean_variance_tb;

  localparam int unsigned SAMPLE_W        = rmv_pkg::SAMPLE_W;
  localparam int unsigned SUM_W           = rmv_pkg::SUM_W;
  localparam int unsigned SEEN_W          = rmv_pkg::SEEN_W;
  localparam int unsigned COUNT_BITS      = 32;
  localparam int unsigned ITEMS_PER_PHASE = 330;
  localparam int unsigned NUM_PHASES      = 4;
  // The longest deliberate receiver hold is HOLD_CYCLES. The watchdog allows
  // several times that hold plus the time one sample takes in the block.
  localparam int unsigned HOLD_CYCLES     = 600;
  localparam int unsigned STALL_LIMIT     = 4000;
  localparam int unsigned MAX_REPORTS     = 10;

  // One input transaction: the flag rides in tuser, the sample in tdata.
  typedef struct packed {
    logic                fresh;
    logic [SAMPLE_W-1:0] sample;
  } sample_item_t;

  // One output transaction, field by field.
  typedef struct packed {
    logic [SAMPLE_W-1:0] mean;
    logic [SUM_W-1:0]    variance;
    logic [SEEN_W-1:0]   seen;
    logic                valid;
  } stats_t;

  // How the samples of one random set are drawn.
  typedef enum int unsigned {
    SET_CLUSTER,  // spread of random width around a random center
    SET_WIDE,     // any 32-bit value
    SET_EXTREME   // mostly the two ends of the range, to push the sum to saturation
  } set_style_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata = '0;    // [31:0] sample
  logic [0:0]   in_tuser = '0;    // [0] starts_new_set
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;        // [31:0] running_mean, [95:32] sample_variance,
                                  // [127:96] samples_seen
  logic [0:0]   out_tuser;        // [0] variance_valid

  running_mean_variance #(
    .COUNT_BITS(COUNT_BITS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Samples waiting to be offered, and the statistics expected back, oldest first.
  sample_item_t pend_q[$];
  stats_t       stats_q[$];

  // Idle rates of the current phase, in percent of cycles.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned in_accepts = 0;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;

  // Receiver hold-off: requested once by the stimulus, counted by the receiver.
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  // Statistics of the current set as the block should hold them.
  logic [COUNT_BITS-1:0]      run_count = '0;
  logic signed [SAMPLE_W-1:0] run_mean = '0;
  logic [SUM_W-1:0]           dev_sum = '0;

  // Welford update for one accepted sample. The first difference is taken
  // against the old mean, the mean moves by that difference divided by the
  // new count (truncated toward zero), and the sum grows by the product of
  // the difference magnitudes against the old and the new mean. Both
  // differences have the same sign, so the product is never negative and
  // fits in 64 bits; only the accumulate can overflow, and it saturates.
  task automatic welford_predict(input sample_item_t it, output stats_t r);
    logic [COUNT_BITS-1:0] n;
    longint                x_val, m_val, d1, d2, m_new;
    longint unsigned       a1, a2, div_n, q, prod;
    logic [SUM_W-1:0]      total;
    r = '0;
    if (it.fresh || run_count == '0) begin
      // First sample of a set: the mean is the sample and there is no spread yet.
      run_count = 1;
      run_mean  = it.sample;
      dev_sum   = '0;
    end else begin
      // The count sticks at its maximum and keeps dividing by that value.
      n      = (run_count == '1) ? run_count : run_count + 1'b1;
      div_n  = n;
      x_val  = longint'($signed(it.sample));
      m_val  = longint'(run_mean);
      d1     = x_val - m_val;
      a1     = (d1 < 0) ? -d1 : d1;
      q      = a1 / div_n;
      m_new  = (d1 < 0) ? m_val - longint'(q) : m_val + longint'(q);
      d2     = x_val - m_new;
      a2     = (d2 < 0) ? -d2 : d2;
      prod   = a1 * a2;
      total  = dev_sum + prod;
      if (total < dev_sum) total = '1;
      dev_sum    = total;
      run_mean   = m_new[SAMPLE_W-1:0];
      run_count  = n;
      r.variance = dev_sum / (div_n - 1);
      r.valid    = 1'b1;
    end
    r.mean = run_mean;
    r.seen = run_count;
  endtask

  task automatic note_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%0t: mismatch: %s", $time, msg);
  endtask

  // Compares one delivered result against the oldest expected one.
  task automatic check_stats(input stats_t got);
    stats_t want;
    if (stats_q.size() == 0) begin
      note_error($sformatf("unexpected result: mean %h variance %h seen %0d valid %b",
                           got.mean, got.variance, got.seen, got.valid));
      return;
    end
    want = stats_q.pop_front();
    if (got.mean !== want.mean)
      note_error($sformatf("running_mean expected %h got %h", want.mean, got.mean));
    if (got.variance !== want.variance)
      note_error($sformatf("sample_variance expected %h got %h",
                           want.variance, got.variance));
    if (got.seen !== want.seen)
      note_error($sformatf("samples_seen expected %0d got %0d", want.seen, got.seen));
    if (got.valid !== want.valid)
      note_error($sformatf("variance_valid expected %b got %b", want.valid, got.valid));
  endtask

  // Driver: moves to the next sample once the current transaction is taken.
  // The expectation is formed at the edge that accepts the sample.
  always @(posedge clk) begin
    sample_item_t it;
    stats_t       r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        welford_predict({in_tuser[0], in_tdata}, r);
        stats_q.insert(stats_q.size(), r);
        in_accepts <= in_accepts + 1;
      end
      if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pend_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= it.sample;
        in_tuser  <= it.fresh;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver and checker. A requested hold-off keeps tready low long enough
  // for the output register to fill and the block to refuse new samples.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready)
        check_stats({out_tdata[31:0], out_tdata[95:32], out_tdata[127:96], out_tuser[0]});
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left  <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        hold_left  <= HOLD_CYCLES;
        hold_done  <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: counts cycles without any transaction while work is outstanding.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (pend_q.size() != 0 || in_tvalid || stats_q.size() != 0) begin
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
          $display("Simulation FAILED");
          $finish;
        end else begin
          quiet_cycles <= quiet_cycles + 1;
        end
      end
    end
  end

  function automatic logic [SAMPLE_W-1:0] draw_sample(input set_style_t style,
                                                      input logic [SAMPLE_W-1:0] center,
                                                      input int unsigned spread);
    logic [SAMPLE_W-1:0] mask;
    mask = (32'd1 << spread) - 1;
    case (style)
      SET_CLUSTER: return center + ($urandom() & mask) - (mask >> 1);
      SET_WIDE:    return $urandom();
      default: begin
        if ($urandom_range(3) == 0) return $urandom();
        return ($urandom_range(1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
    endcase
  endfunction

  function automatic void push_item(input logic fresh, input logic [SAMPLE_W-1:0] sample);
    pend_q.insert(pend_q.size(), {fresh, sample});
  endfunction

  // Mostly well-formed sets that open with the flag and then accumulate;
  // a few sets open without it, and a stray flag now and then cuts a set short.
  task automatic queue_sets(input int unsigned budget);
    int unsigned queued, len, pick, spread;
    set_style_t  style;
    logic [SAMPLE_W-1:0] center;
    queued = 0;
    while (queued < budget) begin
      len  = ($urandom_range(9) == 0) ? $urandom_range(30, 80) : $urandom_range(2, 12);
      pick = $urandom_range(9);
      if (pick < 5) style = SET_CLUSTER;
      else if (pick < 8) style = SET_WIDE;
      else style = SET_EXTREME;
      center = $urandom();
      spread = $urandom_range(1, 31);
      for (int unsigned k = 0; k < len; k++) begin
        push_item((k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0),
                  draw_sample(style, center, spread));
      end
      queued += len;
    end
  endtask

  // Holds the stimulus until every queued sample is taken and every result is in.
  task automatic wait_drain();
    while (pend_q.size() != 0 || in_tvalid || stats_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    int unsigned mark;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed samples. The very first one arrives without the flag, so the
    // empty-count path opens the set.
    push_item(1'b0, 32'h0000_0000);
    push_item(1'b0, 32'h0001_0000);
    push_item(1'b0, 32'h0003_0000);
    // Repeated maximum, then repeated minimum: the variance stays zero.
    push_item(1'b1, 32'h7FFF_FFFF);
    push_item(1'b0, 32'h7FFF_FFFF);
    push_item(1'b1, 32'h8000_0000);
    push_item(1'b0, 32'h8000_0000);
    // Small negative values: the mean step truncates toward zero.
    push_item(1'b1, 32'hFFFF_FFFF);
    push_item(1'b0, 32'hFFFF_FFFE);
    push_item(1'b0, 32'h0000_0000);
    push_item(1'b0, 32'hFFFF_FFFD);
    // Alternating ends of the range drive the squared-deviation sum into saturation.
    for (int unsigned k = 0; k < 10; k++)
      push_item(k == 0, k[0] ? 32'h7FFF_FFFF : 32'h8000_0000);
    // Two sets opened back to back; the second one takes a further sample.
    push_item(1'b1, 32'h5555_AAAA);
    push_item(1'b1, 32'hAAAA_5555);
    push_item(1'b0, 32'h0000_0001);
    wait_drain();

    // Phases of idling: none, sender idle, receiver stalling, both.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        3: begin send_idle_pct = 29; recv_stall_pct = 29; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      queue_sets(ITEMS_PER_PHASE);
      if (p == 0) begin
        // Let a few samples through, then hold the receiver off while the
        // sender keeps offering, so the block backs up into its input.
        mark = in_accepts;
        while (in_accepts < mark + 3) @(negedge clk);
        hold_req = 1'b1;
      end
      wait_drain();
    end

    // Any stray result after the last expected one is caught by the checker.
    repeat (200) @(negedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
